FILE: rtl/core/qbwt_pkg.sv
// shared types, constants and fixed-point helpers for the bone world transform
package qbwt_pkg;

    localparam int unsigned DATA_W    = 32;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned ROT_SUM_W = 36;  // four rounded q30 products
    localparam int unsigned T_W       = 36;  // cross product term, q16.16 unsaturated
    localparam int unsigned POS_SUM_W = 39;  // offset + move + three rounded products
    localparam int unsigned PROD_W    = 68;  // widest product, 32 x 36 bits
    localparam int unsigned RND_W     = PROD_W - 30;

    localparam logic signed [DATA_W-1:0]    Q30_ONE  = 32'sh4000_0000;
    localparam logic signed [PROD_W-1:0]    RND_HALF = 68'sd536870912;
    localparam logic signed [POS_SUM_W-1:0] SAT_MAX  = 39'sd2147483647;
    localparam logic signed [POS_SUM_W-1:0] SAT_MIN  = -39'sd2147483648;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic signed [31:0] w;
    } quat_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } vec_t;

    typedef struct packed {
        quat_t rot;
        vec_t  move;
    } world_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROT_X  = 3'd0,
        REG_ROT_Y  = 3'd1,
        REG_ROT_Z  = 3'd2,
        REG_ROT_W  = 3'd3,
        REG_MOVE_X = 3'd4,
        REG_MOVE_Y = 3'd5,
        REG_MOVE_Z = 3'd6
    } cfg_idx_t;

    // scale a product down by 2^30, round to nearest, ties up
    function automatic logic signed [RND_W-1:0] rnd_q30(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] s;
        s = p + RND_HALF;
        return s[PROD_W-1:30];
    endfunction

    // clamp to the signed 32-bit range
    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [POS_SUM_W-1:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > SAT_MAX) begin
            r = SAT_MAX[DATA_W-1:0];
        end
        else if (v < SAT_MIN) begin
            r = SAT_MIN[DATA_W-1:0];
        end
        else begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

FILE: rtl/core/quaternion_bone_world_transform_core.sv
// top level: world rotation and position of one skinning bone per transaction
// done follows the accepting edge through the valid registers vld1, vld2, vld3 and done
// throughput: one transaction per cycle, four-stage pipeline of 32-bit-class multipliers
// busy is held low; the pipeline never stalls and the receiver cannot stall it
// reset: asynchronous, clears valid bits and loads the identity rotation and zero translation
module quaternion_bone_world_transform_core (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration write port
    input  logic                              cfg_we,
    input  logic [qbwt_pkg::CFG_IDX_W-1:0]    cfg_idx,
    input  logic [qbwt_pkg::DATA_W-1:0]       cfg_wdata,
    // input transaction
    input  logic                              start,
    output logic                              busy,
    input  logic signed [31:0]                bone_rot_x,
    input  logic signed [31:0]                bone_rot_y,
    input  logic signed [31:0]                bone_rot_z,
    input  logic signed [31:0]                bone_rot_w,
    input  logic signed [31:0]                bone_off_x,
    input  logic signed [31:0]                bone_off_y,
    input  logic signed [31:0]                bone_off_z,
    input  logic [31:0]                       bone_alpha,
    input  logic                              last_bone,
    // result transaction
    output logic                              done,
    output logic signed [31:0]                out_rot_x,
    output logic signed [31:0]                out_rot_y,
    output logic signed [31:0]                out_rot_z,
    output logic signed [31:0]                out_rot_w,
    output logic signed [31:0]                out_pos_x,
    output logic signed [31:0]                out_pos_y,
    output logic signed [31:0]                out_pos_z,
    output logic [31:0]                       out_alpha,
    output logic                              out_last
);

    localparam int unsigned RW = qbwt_pkg::ROT_SUM_W;
    localparam int unsigned SW = qbwt_pkg::POS_SUM_W;

    qbwt_pkg::world_t  world;
    qbwt_pkg::quat_t   bone_q;
    qbwt_pkg::vec_t    bone_v;
    logic              accept;

    // valid bits, one per stage
    logic              vld1_reg, vld2_reg, vld3_reg, done_reg;

    // side-band payload that rides along with the arithmetic
    logic [31:0]       alpha1_reg, alpha2_reg, alpha3_reg;
    logic              last1_reg, last2_reg, last3_reg;

    // rotation sums from the product unit, delayed to line up with position
    logic signed [RW-1:0] r_x, r_y, r_z, r_w;
    logic signed [RW-1:0] rot3_x_reg, rot3_y_reg, rot3_z_reg, rot3_w_reg;
    logic signed [SW-1:0] pos_x, pos_y, pos_z;

    // output registers
    logic signed [31:0] out_rot_x_reg, out_rot_y_reg, out_rot_z_reg, out_rot_w_reg;
    logic signed [31:0] out_pos_x_reg, out_pos_y_reg, out_pos_z_reg;
    logic [31:0]        out_alpha_reg;
    logic               out_last_reg;

    // nothing ever holds the pipeline, so a new transaction is taken every cycle
    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign bone_q = '{x: bone_rot_x, y: bone_rot_y, z: bone_rot_z, w: bone_rot_w};
    assign bone_v = '{x: bone_off_x, y: bone_off_y, z: bone_off_z};

    qbwt_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata),
        .world     (world)
    );

    // world * bone, results after stage 2
    qbwt_quat_mul u_quat (
        .clk (clk),
        .a   (world.rot),
        .b   (bone_q),
        .r_x (r_x),
        .r_y (r_y),
        .r_z (r_z),
        .r_w (r_w)
    );

    // rotated offset plus translation, combinational out of stage 3
    qbwt_vec_rot u_vrot (
        .clk   (clk),
        .q     (world.rot),
        .m     (world.move),
        .v     (bone_v),
        .pos_x (pos_x),
        .pos_y (pos_y),
        .pos_z (pos_z)
    );

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            vld1_reg <= accept;
            vld2_reg <= vld1_reg;
            vld3_reg <= vld2_reg;
            done_reg <= vld3_reg;
        end
    end

    // side-band delay line and rotation alignment stage
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            alpha1_reg <= bone_alpha;
            last1_reg  <= last_bone;
        end
        if (vld1_reg)
        begin
            alpha2_reg <= alpha1_reg;
            last2_reg  <= last1_reg;
        end
        if (vld2_reg)
        begin
            alpha3_reg <= alpha2_reg;
            last3_reg  <= last2_reg;
            rot3_x_reg <= r_x;
            rot3_y_reg <= r_y;
            rot3_z_reg <= r_z;
            rot3_w_reg <= r_w;
        end
    end

    // stage 4: saturate every component only at the end
    always_ff @(posedge clk)
    begin
        if (vld3_reg)
        begin
            out_rot_x_reg <= qbwt_pkg::sat32(SW'(rot3_x_reg));
            out_rot_y_reg <= qbwt_pkg::sat32(SW'(rot3_y_reg));
            out_rot_z_reg <= qbwt_pkg::sat32(SW'(rot3_z_reg));
            out_rot_w_reg <= qbwt_pkg::sat32(SW'(rot3_w_reg));
            out_pos_x_reg <= qbwt_pkg::sat32(pos_x);
            out_pos_y_reg <= qbwt_pkg::sat32(pos_y);
            out_pos_z_reg <= qbwt_pkg::sat32(pos_z);
            out_alpha_reg <= alpha3_reg;
            out_last_reg  <= last3_reg;
        end
    end

    // done marks the cycle in which each new result transaction reaches the ports
    assign done      = done_reg;
    assign out_rot_x = out_rot_x_reg;
    assign out_rot_y = out_rot_y_reg;
    assign out_rot_z = out_rot_z_reg;
    assign out_rot_w = out_rot_w_reg;
    assign out_pos_x = out_pos_x_reg;
    assign out_pos_y = out_pos_y_reg;
    assign out_pos_z = out_pos_z_reg;
    assign out_alpha = out_alpha_reg;
    assign out_last  = out_last_reg;

endmodule

FILE: rtl/core/qbwt_cfg_regs.sv
// world rotation and translation configuration registers
module qbwt_cfg_regs (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [qbwt_pkg::CFG_IDX_W-1:0]      cfg_idx,
    input  logic [qbwt_pkg::DATA_W-1:0]         cfg_wdata,
    output qbwt_pkg::world_t                    world
);

    qbwt_pkg::world_t world_reg;
    qbwt_pkg::world_t world_next;

    always_comb
    begin
        world_next = world_reg;
        if (cfg_we)
        begin
            unique case (qbwt_pkg::cfg_idx_t'(cfg_idx))
                qbwt_pkg::REG_ROT_X:  world_next.rot.x  = $signed(cfg_wdata);
                qbwt_pkg::REG_ROT_Y:  world_next.rot.y  = $signed(cfg_wdata);
                qbwt_pkg::REG_ROT_Z:  world_next.rot.z  = $signed(cfg_wdata);
                qbwt_pkg::REG_ROT_W:  world_next.rot.w  = $signed(cfg_wdata);
                qbwt_pkg::REG_MOVE_X: world_next.move.x = $signed(cfg_wdata);
                qbwt_pkg::REG_MOVE_Y: world_next.move.y = $signed(cfg_wdata);
                qbwt_pkg::REG_MOVE_Z: world_next.move.z = $signed(cfg_wdata);
                default:              world_next = world_reg;  // unused index
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            // identity rotation, no translation
            world_reg <= '{rot:  '{x: '0, y: '0, z: '0, w: qbwt_pkg::Q30_ONE},
                           move: '{x: '0, y: '0, z: '0}};
        end
        else
        begin
            world_reg <= world_next;
        end
    end

    assign world = world_reg;

endmodule

FILE: rtl/core/qbwt_quat_mul.sv
// two-stage hamilton product world * bone: products, then rounded sums
module qbwt_quat_mul (
    input  logic                                   clk,
    input  qbwt_pkg::quat_t                        a,
    input  qbwt_pkg::quat_t                        b,
    output logic signed [qbwt_pkg::ROT_SUM_W-1:0]  r_x,
    output logic signed [qbwt_pkg::ROT_SUM_W-1:0]  r_y,
    output logic signed [qbwt_pkg::ROT_SUM_W-1:0]  r_z,
    output logic signed [qbwt_pkg::ROT_SUM_W-1:0]  r_w
);

    localparam int unsigned PW = qbwt_pkg::PROD_W;
    localparam int unsigned SW = qbwt_pkg::ROT_SUM_W;

    logic signed [63:0]   prod_reg [0:15];
    logic signed [SW-1:0] r_x_reg, r_y_reg, r_z_reg, r_w_reg;
    logic signed [SW-1:0] r_x_next, r_y_next, r_z_next, r_w_next;

    function automatic logic signed [SW-1:0] term(input logic signed [63:0] p);
        return SW'(qbwt_pkg::rnd_q30(PW'(p)));
    endfunction

    // stage 1: sixteen 32x32 products
    always_ff @(posedge clk)
    begin
        prod_reg[0]  <= a.w * b.x;
        prod_reg[1]  <= a.x * b.w;
        prod_reg[2]  <= a.y * b.z;
        prod_reg[3]  <= a.z * b.y;
        prod_reg[4]  <= a.w * b.y;
        prod_reg[5]  <= a.x * b.z;
        prod_reg[6]  <= a.y * b.w;
        prod_reg[7]  <= a.z * b.x;
        prod_reg[8]  <= a.w * b.z;
        prod_reg[9]  <= a.x * b.y;
        prod_reg[10] <= a.y * b.x;
        prod_reg[11] <= a.z * b.w;
        prod_reg[12] <= a.w * b.w;
        prod_reg[13] <= a.x * b.x;
        prod_reg[14] <= a.y * b.y;
        prod_reg[15] <= a.z * b.z;
    end

    // stage 2: each product rounded on its own, then an exact sum
    always_comb
    begin
        r_x_next = term(prod_reg[0]) + term(prod_reg[1]) + term(prod_reg[2])
                 - term(prod_reg[3]);
        r_y_next = term(prod_reg[4]) - term(prod_reg[5]) + term(prod_reg[6])
                 + term(prod_reg[7]);
        r_z_next = term(prod_reg[8]) + term(prod_reg[9]) - term(prod_reg[10])
                 + term(prod_reg[11]);
        r_w_next = term(prod_reg[12]) - term(prod_reg[13]) - term(prod_reg[14])
                 - term(prod_reg[15]);
    end

    always_ff @(posedge clk)
    begin
        r_x_reg <= r_x_next;
        r_y_reg <= r_y_next;
        r_z_reg <= r_z_next;
        r_w_reg <= r_w_next;
    end

    assign r_x = r_x_reg;
    assign r_y = r_y_reg;
    assign r_z = r_z_reg;
    assign r_w = r_w_reg;

endmodule

FILE: rtl/core/qbwt_vec_rot.sv
// three-stage offset rotation by the world quaternion plus translation
module qbwt_vec_rot (
    input  logic                                   clk,
    input  qbwt_pkg::quat_t                        q,
    input  qbwt_pkg::vec_t                         m,
    input  qbwt_pkg::vec_t                         v,
    output logic signed [qbwt_pkg::POS_SUM_W-1:0]  pos_x,
    output logic signed [qbwt_pkg::POS_SUM_W-1:0]  pos_y,
    output logic signed [qbwt_pkg::POS_SUM_W-1:0]  pos_z
);

    localparam int unsigned PW = qbwt_pkg::PROD_W;
    localparam int unsigned TW = qbwt_pkg::T_W;
    localparam int unsigned SW = qbwt_pkg::POS_SUM_W;

    logic signed [32:0]   v2_x, v2_y, v2_z;
    logic signed [64:0]   tp_reg [0:5];
    qbwt_pkg::vec_t       v1_reg;
    logic signed [TW-1:0] t0_reg, t1_reg, t2_reg;
    logic signed [TW-1:0] t0_next, t1_next, t2_next;
    logic signed [SW-1:0] vm2_x_reg, vm2_y_reg, vm2_z_reg;
    logic signed [PW-1:0] pp_reg [0:8];
    logic signed [SW-1:0] vm3_x_reg, vm3_y_reg, vm3_z_reg;

    function automatic logic signed [TW-1:0] tterm(input logic signed [64:0] p);
        return TW'(qbwt_pkg::rnd_q30(PW'(p)));
    endfunction

    function automatic logic signed [SW-1:0] pterm(input logic signed [PW-1:0] p);
        return SW'(qbwt_pkg::rnd_q30(p));
    endfunction

    // doubled offset, exact
    assign v2_x = $signed({v.x, 1'b0});
    assign v2_y = $signed({v.y, 1'b0});
    assign v2_z = $signed({v.z, 1'b0});

    // stage 1: products for t = 2 * (q_vec x v)
    always_ff @(posedge clk)
    begin
        tp_reg[0] <= q.y * v2_z;
        tp_reg[1] <= q.z * v2_y;
        tp_reg[2] <= q.z * v2_x;
        tp_reg[3] <= q.x * v2_z;
        tp_reg[4] <= q.x * v2_y;
        tp_reg[5] <= q.y * v2_x;
        v1_reg    <= v;
    end

    // stage 2: t kept at full width, offset plus translation
    always_comb
    begin
        t0_next = tterm(tp_reg[0]) - tterm(tp_reg[1]);
        t1_next = tterm(tp_reg[2]) - tterm(tp_reg[3]);
        t2_next = tterm(tp_reg[4]) - tterm(tp_reg[5]);
    end

    always_ff @(posedge clk)
    begin
        t0_reg    <= t0_next;
        t1_reg    <= t1_next;
        t2_reg    <= t2_next;
        vm2_x_reg <= SW'(v1_reg.x) + SW'(m.x);
        vm2_y_reg <= SW'(v1_reg.y) + SW'(m.y);
        vm2_z_reg <= SW'(v1_reg.z) + SW'(m.z);
    end

    // stage 3: q_w * t and q_vec x t products
    always_ff @(posedge clk)
    begin
        pp_reg[0] <= q.w * t0_reg;
        pp_reg[1] <= q.y * t2_reg;
        pp_reg[2] <= q.z * t1_reg;
        pp_reg[3] <= q.w * t1_reg;
        pp_reg[4] <= q.z * t0_reg;
        pp_reg[5] <= q.x * t2_reg;
        pp_reg[6] <= q.w * t2_reg;
        pp_reg[7] <= q.x * t1_reg;
        pp_reg[8] <= q.y * t0_reg;
        vm3_x_reg <= vm2_x_reg;
        vm3_y_reg <= vm2_y_reg;
        vm3_z_reg <= vm2_z_reg;
    end

    // rounded terms summed exactly, saturated by the caller
    assign pos_x = vm3_x_reg + pterm(pp_reg[0]) + pterm(pp_reg[1]) - pterm(pp_reg[2]);
    assign pos_y = vm3_y_reg + pterm(pp_reg[3]) + pterm(pp_reg[4]) - pterm(pp_reg[5]);
    assign pos_z = vm3_z_reg + pterm(pp_reg[6]) + pterm(pp_reg[7]) - pterm(pp_reg[8]);

endmodule

FILE: rtl/core/qbwt_checker.sv
// port-level checker for the bone world transform core and its bind
module qbwt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic [31:0] bone_alpha,
    input logic        last_bone,
    input logic        done,
    input logic [31:0] out_alpha,
    input logic        out_last
);

    // every accepted transaction gives a result strobe on done
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##4 done)
        else $error("result missing four cycles after an accepted transaction");

    // no result strobe without an accepted transaction
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |-> ##4 !done)
        else $error("result strobe without an accepted transaction");

    // alpha word travels with its transaction
    a_alpha: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (out_alpha == $past(bone_alpha, 4)))
        else $error("alpha word does not match its transaction");

    // last-bone mark travels with its transaction
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (out_last == $past(last_bone, 4)))
        else $error("last-bone mark does not match its transaction");

endmodule

bind quaternion_bone_world_transform_core qbwt_checker u_qbwt_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .bone_alpha (bone_alpha),
    .last_bone  (last_bone),
    .done       (done),
    .out_alpha  (out_alpha),
    .out_last   (out_last)
);
